// ===== hw/rtl/lvn_pkg.sv =====
// Shared types for the link vector normalize block.
`timescale 1ns / 1ps
package lvn_pkg;

  // Number of vector components handled side by side
  localparam int LVN_LANES = 3;

  // Pipeline control that the top level hands to each pipelined unit
  typedef struct packed {
    logic adv;  // whole pipeline moves one stage
    logic vld;  // item entering the unit is valid
  } lvn_ctrl_t;

endpackage

// ===== hw/rtl/lvn_if.sv =====
// Channel interfaces: link items in, normalized results out.
`timescale 1ns / 1ps
interface lvn_link_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] own_x;
  logic signed [COORD_WIDTH-1:0] own_y;
  logic signed [COORD_WIDTH-1:0] own_z;
  logic signed [COORD_WIDTH-1:0] nbr_x;
  logic signed [COORD_WIDTH-1:0] nbr_y;
  logic signed [COORD_WIDTH-1:0] nbr_z;
  logic                          last_link;

  modport source (output valid, own_x, own_y, own_z, nbr_x, nbr_y, nbr_z, last_link,
                  input ready);
  modport sink (input valid, own_x, own_y, own_z, nbr_x, nbr_y, nbr_z, last_link,
                output ready);
endinterface

interface lvn_result_if #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 30
);
  logic                            valid;
  logic                            ready;
  logic signed [COORD_WIDTH:0]     diff_x;
  logic signed [COORD_WIDTH:0]     diff_y;
  logic signed [COORD_WIDTH:0]     diff_z;
  logic [COORD_WIDTH:0]            length;
  logic signed [FRACTION_BITS+1:0] unit_x;
  logic signed [FRACTION_BITS+1:0] unit_y;
  logic signed [FRACTION_BITS+1:0] unit_z;
  logic                            zero_length;
  logic                            link_end;

  modport source (output valid, diff_x, diff_y, diff_z, length, unit_x, unit_y, unit_z,
                  zero_length, link_end, input ready);
  modport sink (input valid, diff_x, diff_y, diff_z, length, unit_x, unit_y, unit_z,
                zero_length, link_end, output ready);
endinterface

// ===== hw/rtl/lvn_isqrt.sv =====
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps
module lvn_isqrt #(
  parameter int RW   = 33,
  parameter int SB_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lvn_pkg::lvn_ctrl_t ctrl_i,
  input  logic [2*RW-1:0]    rad_i,
  input  logic [SB_W-1:0]    sb_i,
  output logic               valid_o,
  output logic [RW-1:0]      root_o,
  output logic [SB_W-1:0]    sb_o
);
  import lvn_pkg::*;

  logic [2*RW-1:0] rad_q  [RW];
  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SB_W-1:0] sb_q   [RW];
  logic [RW-1:0]   vld_q;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [2*RW-1:0] rad_p;
    logic [RW:0]     rem_p;
    logic [RW-1:0]   root_p;
    logic [SB_W-1:0] sb_p;
    logic            vld_p;
    logic [RW+2:0]   tmp;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   sub;
    logic            ge;

    if (i == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign sb_p   = sb_i;
      assign vld_p  = ctrl_i.vld;
    end else begin : g_next
      assign rad_p  = rad_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign root_p = root_q[i-1];
      assign sb_p   = sb_q[i-1];
      assign vld_p  = vld_q[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign tmp   = {rem_p, rad_p[2*RW-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign sub   = tmp - trial;
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctrl_i.adv) begin
        vld_q[i] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.adv) begin
        rad_q[i]  <= {rad_p[2*RW-3:0], 2'b00};
        rem_q[i]  <= ge ? sub[RW:0] : tmp[RW:0];
        root_q[i] <= {root_p[RW-2:0], ge};
        sb_q[i]   <= sb_p;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

  // a finished remainder never exceeds twice the root
  property p_rem_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      valid_o |-> (rem_q[RW-1] <= {root_q[RW-1], 1'b0});
  endproperty
  a_rem_bound: assert property (p_rem_bound) else $error("sqrt remainder out of range");

endmodule

// ===== hw/rtl/lvn_div.sv =====
// Pipelined restoring divider for three lanes sharing one divisor.
`timescale 1ns / 1ps
module lvn_div #(
  parameter int DW   = 33,
  parameter int QW   = 31,
  parameter int SB_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lvn_pkg::lvn_ctrl_t                ctrl_i,
  input  logic [DW-1:0]                     den_i,
  input  logic [lvn_pkg::LVN_LANES-1:0][DW-1:0] mag_i,
  input  logic [SB_W-1:0]                   sb_i,
  output logic                              valid_o,
  output logic [lvn_pkg::LVN_LANES-1:0][QW-1:0] quo_o,
  output logic [SB_W-1:0]                   sb_o
);
  import lvn_pkg::*;

  logic [DW-1:0]   den_q [QW];
  logic [DW-1:0]   rem_q [QW][LVN_LANES];
  logic [QW-1:0]   quo_q [QW][LVN_LANES];
  logic [SB_W-1:0] sb_q  [QW];
  logic [QW-1:0]   vld_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0]   den_p;
    logic [SB_W-1:0] sb_p;
    logic            vld_p;

    if (k == 0) begin : g_first
      assign den_p = den_i;
      assign sb_p  = sb_i;
      assign vld_p = ctrl_i.vld;
    end else begin : g_next
      assign den_p = den_q[k-1];
      assign sb_p  = sb_q[k-1];
      assign vld_p = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.adv) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.adv) begin
        den_q[k] <= den_p;
        sb_q[k]  <= sb_p;
      end
    end

    for (genvar l = 0; l < LVN_LANES; l++) begin : g_lane
      logic [DW-1:0] rem_p;
      logic [QW-1:0] quo_p;
      logic          bit_p;
      logic [DW:0]   tmp;
      logic [DW:0]   sub;
      logic          ge;

      // dividend is mag << FRACTION_BITS; its top part is mag >> 1, below den
      if (k == 0) begin : g_first
        assign rem_p = {1'b0, mag_i[l][DW-1:1]};
        assign quo_p = '0;
        assign bit_p = mag_i[l][0];
      end else begin : g_next
        assign rem_p = rem_q[k-1][l];
        assign quo_p = quo_q[k-1][l];
        assign bit_p = 1'b0;
      end

      assign tmp = {rem_p, bit_p};
      assign sub = tmp - {1'b0, den_p};
      assign ge  = (tmp >= {1'b0, den_p});

      always_ff @(posedge clk_i) begin
        if (ctrl_i.adv) begin
          rem_q[k][l] <= ge ? sub[DW-1:0] : tmp[DW-1:0];
          quo_q[k][l] <= {quo_p[QW-2:0], ge};
        end
      end
    end
  end

  // quotients leave from the last stage
  for (genvar l = 0; l < LVN_LANES; l++) begin : g_quo
    assign quo_o[l] = quo_q[QW-1][l];
  end

  assign valid_o = vld_q[QW-1];
  assign sb_o    = sb_q[QW-1];

  // with a nonzero divisor the final remainder stays below it
  property p_rem_below;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_o && (den_q[QW-1] != '0)) |-> (rem_q[QW-1][0] < den_q[QW-1]);
  endproperty
  a_rem_below: assert property (p_rem_below) else $error("divider remainder too large");

endmodule

// ===== hw/rtl/link_vector_normalize.sv =====
// Top level: link difference vector, floor length and unit direction.
//
//   channel   dir   transfer when          payload
//   link_i    in    valid && ready         own_x/y/z, nbr_x/y/z, last_link
//   result_o  out   valid && ready         diff_x/y/z, length, unit_x/y/z, zero_length, link_end
//
// One link per cycle while the output is not stalled. The pipeline holds four front
// stages, COORD_WIDTH + 1 root stages, one mag stage,
// FRACTION_BITS + 1 quotient stages, and the output register.
// A stalled output freezes the whole pipeline; link_i.ready drops only then.
// Reset clears the stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
module link_vector_normalize #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 30
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lvn_link_if.sink     link_i,
  lvn_result_if.source result_o
);
  import lvn_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int QW   = FRACTION_BITS + 1;
  localparam int UW   = FRACTION_BITS + 2;
  localparam int SQSB = LVN_LANES * DW + 1;
  localparam int DVSB = LVN_LANES * DW + DW + 1;

  logic adv;
  assign adv          = !result_o.valid || result_o.ready;
  assign link_i.ready = adv;

  // stage 1: differences
  logic [LVN_LANES-1:0][DW-1:0] d1_q, d2_q, d3_q, d4_q, d5_q;
  logic [LVN_LANES-1:0][DW-1:0] d1_d;
  logic                         last1_q, last2_q, last3_q, last4_q, last5_q;
  logic                         v1_q, v2_q, v3_q, v4_q, v5_q;

  assign d1_d[0] = {link_i.nbr_x[COORD_WIDTH-1], link_i.nbr_x}
                 - {link_i.own_x[COORD_WIDTH-1], link_i.own_x};
  assign d1_d[1] = {link_i.nbr_y[COORD_WIDTH-1], link_i.nbr_y}
                 - {link_i.own_y[COORD_WIDTH-1], link_i.own_y};
  assign d1_d[2] = {link_i.nbr_z[COORD_WIDTH-1], link_i.nbr_z}
                 - {link_i.own_z[COORD_WIDTH-1], link_i.own_z};

  // stage 2: magnitudes; stage 3: squares; stage 4: sum
  logic [LVN_LANES-1:0][DW-1:0]   mag2_q, mag2_d;
  logic [LVN_LANES-1:0][2*DW-1:0] sq3_q;
  logic [2*DW-1:0]                sum4_q;

  for (genvar l = 0; l < LVN_LANES; l++) begin : g_abs
    assign mag2_d[l] = d1_q[l][DW-1] ? (~d1_q[l] + 1'b1) : d1_q[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= link_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q    <= d1_d;
      last1_q <= link_i.last_link;
      mag2_q  <= mag2_d;
      d2_q    <= d1_q;
      last2_q <= last1_q;
      for (int l = 0; l < LVN_LANES; l++) begin
        sq3_q[l] <= mag2_q[l] * mag2_q[l];
      end
      d3_q    <= d2_q;
      last3_q <= last2_q;
      sum4_q  <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      d4_q    <= d3_q;
      last4_q <= last3_q;
    end
  end

  // square root over the sum of squares
  lvn_ctrl_t       sq_ctrl;
  logic            sq_valid;
  logic [DW-1:0]   sq_root;
  logic [SQSB-1:0] sq_sb;

  assign sq_ctrl.adv = adv;
  assign sq_ctrl.vld = v4_q;

  lvn_isqrt #(
    .RW   (DW),
    .SB_W (SQSB)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sq_ctrl),
    .rad_i   (sum4_q),
    .sb_i    ({last4_q, d4_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // stage 5: length and magnitudes for the divider
  logic [DW-1:0]                len5_q;
  logic [LVN_LANES-1:0][DW-1:0] mag5_q, mag5_d, d5_d;

  assign d5_d = sq_sb[LVN_LANES*DW-1:0];
  for (genvar l = 0; l < LVN_LANES; l++) begin : g_abs5
    assign mag5_d[l] = d5_d[l][DW-1] ? (~d5_d[l] + 1'b1) : d5_d[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len5_q  <= sq_root;
      mag5_q  <= mag5_d;
      d5_q    <= d5_d;
      last5_q <= sq_sb[SQSB-1];
    end
  end

  // divider: mag << FRACTION_BITS over length, per lane
  lvn_ctrl_t                    dv_ctrl;
  logic                         dv_valid;
  logic [LVN_LANES-1:0][QW-1:0] dv_quo;
  logic [DVSB-1:0]              dv_sb;

  assign dv_ctrl.adv = adv;
  assign dv_ctrl.vld = v5_q;

  lvn_div #(
    .DW   (DW),
    .QW   (QW),
    .SB_W (DVSB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dv_ctrl),
    .den_i   (len5_q),
    .mag_i   (mag5_q),
    .sb_i    ({len5_q, last5_q, d5_q}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  // output register: sign the quotients, clear them on zero length
  logic [LVN_LANES-1:0][DW-1:0] fd;
  logic [DW-1:0]                flen;
  logic                         fzero;
  logic [LVN_LANES-1:0][UW-1:0] funit;
  logic                         out_v_q;

  assign fd    = dv_sb[LVN_LANES*DW-1:0];
  assign flen  = dv_sb[DVSB-1 -: DW];
  assign fzero = (flen == '0);

  for (genvar l = 0; l < LVN_LANES; l++) begin : g_sign
    logic [UW-1:0] mag_u;
    assign mag_u    = {1'b0, dv_quo[l]};
    assign funit[l] = fzero ? '0 : (fd[l][DW-1] ? (~mag_u + 1'b1) : mag_u);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_o.diff_x      <= fd[0];
      result_o.diff_y      <= fd[1];
      result_o.diff_z      <= fd[2];
      result_o.length      <= flen;
      result_o.unit_x      <= funit[0];
      result_o.unit_y      <= funit[1];
      result_o.unit_z      <= funit[2];
      result_o.zero_length <= fzero;
      result_o.link_end    <= dv_sb[LVN_LANES*DW];
    end
  end

  assign result_o.valid = out_v_q;

  // zero length flag matches the length field and forces a zero unit vector
  property p_zero_flag;
    @(posedge clk_i) disable iff (!rst_ni)
      result_o.valid |-> (result_o.zero_length == (result_o.length == '0));
  endproperty
  a_zero_flag: assert property (p_zero_flag) else $error("zero_length disagrees with length");

  property p_zero_unit;
    @(posedge clk_i) disable iff (!rst_ni)
      (result_o.valid && result_o.zero_length) |->
        (result_o.unit_x == '0 && result_o.unit_y == '0 && result_o.unit_z == '0);
  endproperty
  a_zero_unit: assert property (p_zero_unit) else $error("unit vector not cleared");

  // a component's length never exceeds the vector length
  property p_len_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      v5_q |-> (mag5_q[0] <= len5_q && mag5_q[1] <= len5_q && mag5_q[2] <= len5_q);
  endproperty
  a_len_bound: assert property (p_len_bound) else $error("component above length");

endmodule

// ===== tb/lvn_checker.sv =====
// Checker: watches link and result transfers, predicts and compares results.
`timescale 1ns / 1ps
module lvn_checker #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  lvn_link_if.sink     link_i,
  lvn_result_if.sink   result_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic signed [COORD_WIDTH:0]     diff_x;
    logic signed [COORD_WIDTH:0]     diff_y;
    logic signed [COORD_WIDTH:0]     diff_z;
    logic [COORD_WIDTH:0]            length;
    logic signed [FRACTION_BITS+1:0] unit_x;
    logic signed [FRACTION_BITS+1:0] unit_y;
    logic signed [FRACTION_BITS+1:0] unit_z;
    logic                            zero_length;
    logic                            link_end;
  } link_result_t;

  link_result_t expected_results[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  // Floor square root of a 128-bit sum, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0] root;
    logic [63:0] t;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (128'(t) * 128'(t) <= s) root = t;
    end
    return root;
  endfunction

  // Direction and length of one link
  function automatic link_result_t normalize_link(
      logic signed [COORD_WIDTH-1:0] own[3], logic signed [COORD_WIDTH-1:0] nbr[3],
      logic last);
    link_result_t r;
    logic signed [COORD_WIDTH+1:0] d[3];
    logic [COORD_WIDTH+1:0] mag[3];
    logic [127:0] sum;
    logic [63:0] len;
    logic [127:0] q;
    logic signed [FRACTION_BITS+1:0] u[3];
    sum = '0;
    for (int l = 0; l < 3; l++) begin
      d[l] = (COORD_WIDTH+2)'(nbr[l]) - (COORD_WIDTH+2)'(own[l]);
      mag[l] = d[l] < 0 ? -d[l] : d[l];
      sum += 128'(mag[l]) * 128'(mag[l]);
    end
    len = floor_sqrt(sum);
    for (int l = 0; l < 3; l++) begin
      u[l] = '0;
      if (len != 0) begin
        q = (128'(mag[l]) << FRACTION_BITS) / 128'(len);
        u[l] = d[l] < 0 ? -q[FRACTION_BITS+1:0] : q[FRACTION_BITS+1:0];
      end
    end
    r.diff_x = d[0][COORD_WIDTH:0];
    r.diff_y = d[1][COORD_WIDTH:0];
    r.diff_z = d[2][COORD_WIDTH:0];
    r.length = len[COORD_WIDTH:0];
    r.unit_x = u[0];
    r.unit_y = u[1];
    r.unit_z = u[2];
    r.zero_length = (len == 0);
    r.link_end = last;
    return r;
  endfunction

  // Predict on link transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    link_result_t got;
    link_result_t want;
    logic signed [COORD_WIDTH-1:0] own[3];
    logic signed [COORD_WIDTH-1:0] nbr[3];
    if (!rst_ni) begin
      fails <= 0;
      expected_results.delete();
    end else begin
      if (link_i.valid && link_i.ready) begin
        own = '{link_i.own_x, link_i.own_y, link_i.own_z};
        nbr = '{link_i.nbr_x, link_i.nbr_y, link_i.nbr_z};
        expected_results.push_back(normalize_link(own, nbr, link_i.last_link));
      end
      if (result_i.valid && result_i.ready) begin
        got = '{result_i.diff_x, result_i.diff_y, result_i.diff_z, result_i.length,
                result_i.unit_x, result_i.unit_y, result_i.unit_z,
                result_i.zero_length, result_i.link_end};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fails <= fails + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected diff %0d %0d %0d len %0d unit %0d %0d %0d z%0b e%0b",
                     $time, want.diff_x, want.diff_y, want.diff_z, want.length,
                     want.unit_x, want.unit_y, want.unit_z, want.zero_length, want.link_end);
            $display("%0t:          actual   diff %0d %0d %0d len %0d unit %0d %0d %0d z%0b e%0b",
                     $time, got.diff_x, got.diff_y, got.diff_z, got.length,
                     got.unit_x, got.unit_y, got.unit_z, got.zero_length, got.link_end);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_link_vector_normalize.sv =====
// Testbench top: link stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module tb_link_vector_normalize;

  localparam int CW = 32;
  localparam int FB = 30;
  localparam int LATENCY = CW + FB + 8;
  localparam int RANDOM_LINKS = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count;
  int pending;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;

  lvn_link_if #(.COORD_WIDTH(CW)) link_ch ();
  lvn_result_if #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) result_ch ();

  link_vector_normalize #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .link_i(link_ch.sink), .result_o(result_ch.source)
  );

  lvn_checker #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .link_i(link_ch.sink), .result_i(result_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    link_ch.valid = 1'b0;
    link_ch.own_x = '0; link_ch.own_y = '0; link_ch.own_z = '0;
    link_ch.nbr_x = '0; link_ch.nbr_y = '0; link_ch.nbr_z = '0;
    link_ch.last_link = 1'b0;
    result_ch.ready = 1'b0;
  end

  // Random coordinate: extremes, small offsets, or full range
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      1, 2: return CW'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  // Offer one link, after an optional random gap, and wait for its transfer
  task automatic send_link(logic [CW-1:0] ox, oy, oz, nx, ny, nz, logic last);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      link_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    link_ch.valid <= 1'b1;
    link_ch.own_x <= ox; link_ch.own_y <= oy; link_ch.own_z <= oz;
    link_ch.nbr_x <= nx; link_ch.nbr_y <= ny; link_ch.nbr_z <= nz;
    link_ch.last_link <= last;
    do @(posedge clk_i); while (!link_ch.ready);
  endtask

  // Back-to-back links with no gap
  task automatic send_burst(int n);
    for (int i = 0; i < n; i++) begin
      link_ch.valid <= 1'b1;
      link_ch.own_x <= rand_coord(); link_ch.own_y <= rand_coord();
      link_ch.own_z <= rand_coord(); link_ch.nbr_x <= rand_coord();
      link_ch.nbr_y <= rand_coord(); link_ch.nbr_z <= rand_coord();
      link_ch.last_link <= 1'($urandom);
      do @(posedge clk_i); while (!link_ch.ready);
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_done <= 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        result_ch.ready <= 1'b1;
        do @(posedge clk_i); while (!result_ch.valid);
      end
    end
  end

  localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: coinciding points, extremes, axis and diagonal links
    send_link('0, '0, '0, '0, '0, '0, 1'b1);
    send_link(MAXC, MINC, 5, MAXC, MINC, 5, 1'b0);
    send_link(MINC, MINC, MINC, MAXC, MAXC, MAXC, 1'b1);
    send_link(MAXC, MAXC, MAXC, MINC, MINC, MINC, 1'b0);
    send_link(MINC, 0, 0, MAXC, 0, 0, 1'b0);
    send_link(0, MAXC, 0, 0, MINC, 0, 1'b1);
    send_link(0, 0, 0, 0, 0, -1, 1'b0);
    send_link(0, 0, 0, 1, 1, 1, 1'b0);
    send_link(0, 0, 0, 3, -4, 0, 1'b1);
    send_link(-1, -1, -1, 0, 0, 0, 1'b0);
    send_link('1, '1, '1, '0, '0, '0, 1'b1);
    send_link(0, 0, 0, 1, 0, 0, 1'b0);
    link_ch.valid <= 1'b0;
    // Sender pause until everything has drained
    wait (pending == 0);
    repeat (LATENCY) @(posedge clk_i);
    // Long receiver hold-off while links keep coming
    hold_off <= 1'b1;
    send_burst(120);
    link_ch.valid <= 1'b0;
    wait (hold_done);
    @(posedge clk_i);
    for (int i = 0; i < RANDOM_LINKS - 120; i++) begin
      if (i % 50 < 10) send_burst(1);
      else if ($urandom_range(0, 9) == 0)
        send_link(32'(i), 7, -7, 32'(i), 7, -7, 1'($urandom));
      else
        send_link(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
    end
    link_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
